FILE: src/tce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types and constants for the text console character engine.
// ----------------------------------------------------------------------------
package tce_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Cell layout: attribute in the high byte, character in the low byte
  localparam int CELL_W = 16;

  // Character codes
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam int         TAB_STEP = 8;

  // Blank light grey on black, loaded by the reset sweep
  localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;

  // Configuration registers
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG = 2'd1;
  localparam logic [3:0] FG_RESET = 4'd7;
  localparam logic [3:0] BG_RESET = 4'd0;

  // Commands
  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SET   = 2'd2,
    CMD_READ  = 2'd3
  } tce_cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_INIT   = 3'd0,
    ST_IDLE   = 3'd1,
    ST_SCROLL = 3'd2,
    ST_FILL   = 3'd3,
    ST_RESULT = 3'd4
  } tce_state_t;

endpackage

FILE: src/tce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/text_console_char_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_engine_top
// Text console engine: a ROWS x COLUMNS character-cell screen in RAM plus a
// cursor, driven by put-char, clear, set-cursor and read-cell commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command per transfer; the
//   output channel (out_valid/out_stall) returns exactly one result per
//   command: the linear cursor position and, for read cell, the cell data.
//   cfg_we/cfg_index/cfg_wdata set the foreground and background colours;
//   write them only while the engine is idle.
//   Put char, set cursor and read cell pass from the input transfer through
//   the result state to the output register; no new command is taken until
//   the engine is back in idle. Clear screen sweeps the single RAM write port.
//   A put char that scrolls copies the screen up through the RAM (one cell
//   per cycle) and then clears the bottom row.
//   Reset: after rst_n is released, a sweep writes blank grey-on-black cells;
//   in_stall stays high during the sweep, while configuration writes are
//   still taken.
//   A stalled result holds on the output register; the next command is taken
//   only when that register is free or being drained in the same cycle.
// ----------------------------------------------------------------------------
module text_console_char_engine_top #(
  parameter int COLUMNS = tce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tce_pkg::ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration port
  input  logic                           cfg_we,
  input  logic [tce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tce_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_cmd,
  input  logic [7:0]                     in_char_code,
  input  logic [6:0]                     in_cell_x,
  input  logic [4:0]                     in_cell_y,
  // Result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [10:0]                    out_cursor_pos,
  output logic [15:0]                    out_cell_data
);

  import tce_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW  = $clog2(CELL_COUNT);
  localparam int SW  = $clog2(CELL_COUNT + 1);
  localparam int CW  = $clog2(COLUMNS + 1);
  localparam int CW1 = CW + 1;
  localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PW  = (SW > 11) ? SW : 11;

  // State
  tce_state_t        state_r, state_nxt;
  logic [SW-1:0]     scan_r;
  logic              cp_valid_r;
  logic [AW-1:0]     cp_addr_r;
  logic [CELL_W-1:0] fill_cell_r;
  logic [CW-1:0]     col_r;
  logic [RW-1:0]     row_r;
  logic [3:0]        fg_r;
  logic [3:0]        bg_r;
  logic              wr_pend_r;
  logic [AW-1:0]     wr_addr_r;
  logic [CELL_W-1:0] wr_cell_r;
  logic              rd_hit_r;
  logic              out_valid_r;
  logic [10:0]       out_pos_r;
  logic [15:0]       out_data_r;

  // RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // Command decode
  logic              acc;
  logic              out_free;
  logic [7:0]        attr;
  logic              last_row;
  logic [RW-1:0]     nl_row;
  logic [CW1-1:0]    tab_col;
  logic              wrap_pend;
  logic [CW-1:0]     col_put;
  logic [RW-1:0]     row_put;
  logic              scroll_put;
  logic              wr_put;
  logic [RW-1:0]     trow;
  logic [CW-1:0]     tcol;
  logic [AW-1:0]     put_addr;
  logic              x_over;
  logic              y_over;
  logic              rd_in_range;
  logic [AW-1:0]     rd_cell_addr;
  logic              sweep_end;
  logic [PW-1:0]     pos_full;

  tce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign acc       = in_valid && !in_stall;
  assign attr      = {bg_r, fg_r};
  assign sweep_end = (scan_r == SW'(CELL_COUNT - 1));

  // Decode put char: cursor movement, target cell and scroll request
  always_comb begin
    last_row   = (row_r == RW'(ROWS - 1));
    nl_row     = last_row ? row_r : RW'(row_r + RW'(1));
    tab_col    = (CW1'(col_r) + CW1'(TAB_STEP)) & ~CW1'(TAB_STEP - 1);
    wrap_pend  = (col_r >= CW'(COLUMNS));
    col_put    = col_r;
    row_put    = row_r;
    scroll_put = 1'b0;
    wr_put     = 1'b0;
    trow       = row_r;
    tcol       = col_r;
    if (in_char_code == CH_LF) begin
      col_put    = '0;
      row_put    = nl_row;
      scroll_put = last_row;
    end else if (in_char_code == CH_CR) begin
      col_put = '0;
    end else if (in_char_code == CH_TAB) begin
      if (tab_col >= CW1'(COLUMNS)) begin
        col_put    = '0;
        row_put    = nl_row;
        scroll_put = last_row;
      end else begin
        col_put = tab_col[CW-1:0];
      end
    end else begin
      wr_put = 1'b1;
      if (wrap_pend) begin
        trow       = nl_row;
        tcol       = '0;
        col_put    = CW'(1);
        row_put    = nl_row;
        scroll_put = last_row;
      end else begin
        col_put = col_r + CW'(1);
      end
    end
    put_addr = AW'(AW'(trow) * AW'(COLUMNS) + AW'(tcol));
  end

  // Decode set cursor and read cell, and the linear cursor position
  always_comb begin
    x_over       = (8'(in_cell_x) >= 8'(COLUMNS));
    y_over       = (7'(in_cell_y) >= 7'(ROWS));
    rd_in_range  = !x_over && !y_over;
    rd_cell_addr = AW'(AW'(in_cell_y) * AW'(COLUMNS) + AW'(in_cell_x));
    pos_full     = PW'(PW'(row_r) * PW'(COLUMNS) + PW'(col_r));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sweep_end) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          case (in_cmd)
            CMD_PUT:   state_nxt = scroll_put ? ST_SCROLL : ST_RESULT;
            CMD_CLEAR: state_nxt = ST_FILL;
            default:   state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_SCROLL: begin
        if (scan_r == SW'(CELL_COUNT)) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (sweep_end) state_nxt = ST_RESULT;
      end
      ST_RESULT: state_nxt = ST_IDLE;
      default:   state_nxt = ST_INIT;
    endcase
  end

  // Outputs of the sequencer: RAM port steering and input stall
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = scan_r[AW-1:0];
    ram_wdata = fill_cell_r;
    ram_raddr = rd_cell_addr;
    case (state_r)
      ST_INIT, ST_FILL: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        in_stall = !out_free;
      end
      ST_SCROLL: begin
        ram_we    = cp_valid_r;
        ram_waddr = cp_addr_r;
        ram_wdata = ram_rdata;
        ram_raddr = scan_r[AW-1:0];
      end
      ST_RESULT: begin
        ram_we    = wr_pend_r;
        ram_waddr = wr_addr_r;
        ram_wdata = wr_cell_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer, sweep counter and copy pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      scan_r      <= '0;
      cp_valid_r  <= 1'b0;
      fill_cell_r <= BLANK_RESET;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_INIT, ST_FILL: begin
          scan_r <= scan_r + SW'(1);
        end
        ST_IDLE: begin
          if (acc) begin
            fill_cell_r <= {attr, CH_SPACE};
            scan_r      <= (in_cmd == CMD_CLEAR) ? '0 : SW'(COLUMNS);
          end
        end
        ST_SCROLL: begin
          if (scan_r != SW'(CELL_COUNT)) begin
            cp_valid_r <= 1'b1;
            cp_addr_r  <= AW'(scan_r - SW'(COLUMNS));
            scan_r     <= scan_r + SW'(1);
          end else begin
            cp_valid_r <= 1'b0;
            scan_r     <= SW'((ROWS - 1) * COLUMNS);
          end
        end
        default: begin
          cp_valid_r <= 1'b0;
        end
      endcase
    end
  end

  // Cursor and pending cell write, updated at the input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      wr_pend_r <= 1'b0;
      rd_hit_r  <= 1'b0;
    end else if (acc) begin
      wr_pend_r <= (in_cmd == CMD_PUT) && wr_put;
      rd_hit_r  <= (in_cmd == CMD_READ) && rd_in_range;
      wr_addr_r <= put_addr;
      wr_cell_r <= {attr, in_char_code};
      case (in_cmd)
        CMD_PUT: begin
          col_r <= col_put;
          row_r <= row_put;
        end
        CMD_CLEAR: begin
          col_r <= '0;
          row_r <= '0;
        end
        CMD_SET: begin
          col_r <= x_over ? CW'(COLUMNS - 1) : CW'(in_cell_x);
          row_r <= y_over ? RW'(ROWS - 1) : RW'(in_cell_y);
        end
        default: begin
          col_r <= col_r;
        end
      endcase
    end
  end

  // Colour registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_FG) fg_r <= cfg_wdata;
      if (cfg_index == REG_BG) bg_r <= cfg_wdata;
    end
  end

  // Result register: load at the end of a command, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_RESULT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESULT) begin
      out_pos_r  <= pos_full[10:0];
      out_data_r <= rd_hit_r ? ram_rdata : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_cell_data  = out_data_r;

`ifndef SYNTHESIS
  // A command transfer always takes the engine out of idle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> in_stall)
    else $error("engine accepted a command without leaving idle");

  // A new result appears only from the result state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RESULT))
    else $error("result raised outside the result state");

  // Result state never finds the output register occupied
  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT) |-> !out_valid_r)
    else $error("result overwrote an undelivered result");

  // Cursor stays on the screen, column at most one past the edge
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r <= RW'(ROWS - 1)) && (col_r <= CW'(COLUMNS)))
    else $error("cursor out of range");
`endif

endmodule
